// ===== hdl/cmt_pkg.sv =====
// Shared types and constants for the cylinder mesh tessellator.
// Holds pipeline latencies, the CORDIC arc table, register indexes and the vertex word.
// No dependencies.
package cmt_pkg;

	localparam int DIV_STEPS = 32;
	localparam int DIV_LAT = DIV_STEPS + 1;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304
	};

	localparam logic [2:0] REG_RADIUS_BASE = 3'd0;
	localparam logic [2:0] REG_RADIUS_TOP = 3'd1;
	localparam logic [2:0] REG_CYL_HEIGHT = 3'd2;
	localparam logic [2:0] REG_SLICE_COUNT = 3'd3;
	localparam logic [2:0] REG_STACK_COUNT = 3'd4;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [16:0] tu;
		logic [16:0] tv;
		logic signed [17:0] nx;
		logic signed [17:0] nz;
		logic border;
		logic [20:0] first;
		logic [20:0] second;
	} vtx_t;

endpackage

// ===== hdl/cmt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded half up at the end.
// Requires num >> QW below den. Uses cmt_pkg for nothing; stand-alone.
module cmt_div #(
	parameter int DW = 11,
	parameter int QW = 32
) (
	input  logic               clk,
	input  logic [DW+QW-1:0]   num,
	input  logic [DW-1:0]      den,
	output logic [QW-1:0]      quo
);

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] numr_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic          bump;

	assign rem_s[0] = num[DW+QW-1:QW];
	assign numr_s[0] = num[QW-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;
		logic [DW:0] diff;
		assign trial = {rem_s[k], numr_s[k][QW-1]};
		assign ge = trial >= {1'b0, den_s[k]};
		assign diff = trial - {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			numr_s[k+1] <= {numr_s[k][QW-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			den_s[k+1] <= den_s[k];
		end
	end

	assign bump = ({1'b0, rem_s[QW]} + {2'b0, den_s[QW][DW-1:1]}) >= {1'b0, den_s[QW]};

	always_ff @(posedge clk) begin
		quo <= quo_s[QW] + QW'(bump);
	end

endmodule

// ===== hdl/cmt_dly.sv =====
// Delay line for a word and its valid bit, N register stages.
// Stand-alone; used to align side data with the divider and CORDIC pipes.
module cmt_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         vld_q [N];
	logic [W-1:0] dat_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dat_q[0] <= in_data;
		for (int k = 1; k < N; k++) dat_q[k] <= dat_q[k-1];
	end

	assign out_valid = vld_q[N-1];
	assign out_data = dat_q[N-1];

endmodule

// ===== hdl/cmt_cordic.sv =====
// Pipelined CORDIC rotation giving cosine and sine of a phase in 2^-32 turn, Q1.16 out.
// Depends on cmt_pkg for the arc table, gain and step count.
module cmt_cordic (
	input  logic               clk,
	input  logic [31:0]        phase,
	input  logic               seam,
	output logic signed [17:0] cs,
	output logic signed [17:0] sn
);

	logic signed [33:0] x_s [cmt_pkg::CORDIC_STEPS+1];
	logic signed [33:0] y_s [cmt_pkg::CORDIC_STEPS+1];
	logic signed [33:0] a_s [cmt_pkg::CORDIC_STEPS+1];
	logic               flip_s [cmt_pkg::CORDIC_STEPS+1];
	logic               seam_s [cmt_pkg::CORDIC_STEPS+1];
	logic signed [33:0] a_ext;
	logic signed [33:0] xf;
	logic signed [33:0] yf;

	function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
		logic [33:0] mag;
		logic [33:0] sum;
		logic [19:0] q;
		logic [17:0] r;
		mag = v[33] ? 34'(-v) : v;
		sum = mag + 34'd8192;
		q = sum[33:14];
		if (q > 20'd65536) q = 20'd65536;
		r = q[17:0];
		to_q16 = v[33] ? $signed(-r) : $signed(r);
	endfunction

	assign a_ext = {{2{phase[31]}}, phase};

	always_ff @(posedge clk) begin
		x_s[0] <= cmt_pkg::CORDIC_GAIN;
		y_s[0] <= '0;
		seam_s[0] <= seam;
		if (a_ext > 34'sd1073741824) begin
			a_s[0] <= a_ext - 34'sd2147483648;
			flip_s[0] <= 1'b1;
		end else if (a_ext <= -34'sd1073741824) begin
			a_s[0] <= a_ext + 34'sd2147483648;
			flip_s[0] <= 1'b1;
		end else begin
			a_s[0] <= a_ext;
			flip_s[0] <= 1'b0;
		end
	end

	for (genvar k = 0; k < cmt_pkg::CORDIC_STEPS; k++) begin : g_rot
		logic signed [33:0] arc;
		assign arc = $signed({4'b0, cmt_pkg::ATAN_TURN[k]});
		always_ff @(posedge clk) begin
			if (!a_s[k][33]) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] - arc;
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] + arc;
			end
			flip_s[k+1] <= flip_s[k];
			seam_s[k+1] <= seam_s[k];
		end
	end

	assign xf = flip_s[cmt_pkg::CORDIC_STEPS] ? -x_s[cmt_pkg::CORDIC_STEPS]
		: x_s[cmt_pkg::CORDIC_STEPS];
	assign yf = flip_s[cmt_pkg::CORDIC_STEPS] ? -y_s[cmt_pkg::CORDIC_STEPS]
		: y_s[cmt_pkg::CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (seam_s[cmt_pkg::CORDIC_STEPS]) begin
			cs <= 18'sd65536;
			sn <= '0;
		end else begin
			cs <= to_q16(xf);
			sn <= to_q16(yf);
		end
	end

endmodule

// ===== hdl/cmt_emit.sv =====
// Result sequencer: one word for a border vertex, two triangle words for an interior one.
// Depends on cmt_pkg for the vertex word.
module cmt_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cmt_pkg::vtx_t       in_vtx,
	output logic                strobe,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_z,
	output logic [16:0]         tex_u,
	output logic [16:0]         tex_v,
	output logic signed [17:0]  norm_x,
	output logic signed [17:0]  norm_z,
	output logic                tri_valid,
	output logic [20:0]         tri_idx_a,
	output logic [20:0]         tri_idx_b,
	output logic [20:0]         tri_idx_c,
	output logic                last_result
);

	logic        strobe_q;
	logic        pend_q;
	logic        last_q;
	logic [20:0] second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			pend_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			strobe_q <= in_valid | pend_q;
			pend_q <= in_valid & ~in_vtx.border;
			if (in_valid) last_q <= in_vtx.border;
			else if (pend_q) last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			pos_x <= in_vtx.px;
			pos_y <= in_vtx.py;
			pos_z <= in_vtx.pz;
			tex_u <= in_vtx.tu;
			tex_v <= in_vtx.tv;
			norm_x <= in_vtx.nx;
			norm_z <= in_vtx.nz;
			second_q <= in_vtx.second;
			tri_valid <= ~in_vtx.border;
			tri_idx_a <= in_vtx.border ? '0 : in_vtx.first + 21'd1;
			tri_idx_b <= in_vtx.border ? '0 : in_vtx.second + 21'd1;
			tri_idx_c <= in_vtx.border ? '0 : in_vtx.first;
		end else if (pend_q) begin
			tri_idx_a <= second_q + 21'd1;
			tri_idx_b <= second_q;
		end
	end

	assign strobe = strobe_q;
	assign last_result = last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !in_valid) else $error("vertex arrived during second triangle");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q && last_q) else $error("second triangle missing");
	a_border_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !tri_valid |-> last_q) else $error("border word not last");

endmodule

// ===== hdl/cylinder_mesh_tessellator_unit.sv =====
// Top level of the tapered cylinder tessellator: registers, index prep, dividers, trig, scaling.
// Depends on cmt_pkg, cmt_div, cmt_dly, cmt_cordic and cmt_emit.
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// command  | start / busy         | slice_index, stack_index
// result   | strobe (no backpress)| pos_*, tex_*, norm_*, tri_*, last_result
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Busy is high the cycle after each accept, so no new grid point is taken in that cycle.
// The first result strobes after accept through 3 prep stages, a 33-stage bit-per-stage
// divider, a 22-stage CORDIC, 2 scaling stages and the output register.
// Interior points give two words on consecutive cycles, border points one.
// arst_n clears valids and loads register defaults; results are never held off.
module cylinder_mesh_tessellator_unit #(
	parameter int MAX_SLICES = 1024,
	parameter int MAX_STACKS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [10:0]        slice_index,
	input  logic [10:0]        stack_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               strobe,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic signed [17:0] norm_x,
	output logic signed [17:0] norm_z,
	output logic               tri_valid,
	output logic [20:0]        tri_idx_a,
	output logic [20:0]        tri_idx_b,
	output logic [20:0]        tri_idx_c,
	output logic               last_result
);

	typedef struct packed {
		logic        seam;
		logic        border;
		logic        py_neg;
		logic [20:0] first;
		logic [20:0] second;
	} side1_t;

	typedef struct packed {
		logic [30:0]        rad;
		logic [16:0]        tu;
		logic [16:0]        tv;
		logic signed [31:0] py;
		logic               border;
		logic [20:0]        first;
		logic [20:0]        second;
	} side2_t;

	logic [30:0] radius_base_q;
	logic [30:0] radius_top_q;
	logic [30:0] cyl_height_q;
	logic [10:0] slice_count_q;
	logic [10:0] stack_count_q;
	logic        busy_q;
	logic        accept;

	logic [10:0] s_sat;
	logic [10:0] t_sat;
	logic [10:0] i_sat;
	logic [10:0] j_sat;

	logic        v_s1;
	logic [10:0] i_s1;
	logic [10:0] j_s1;
	logic [10:0] s_s1;
	logic [10:0] t_s1;

	logic [11:0] two_j;
	logic [11:0] t12;
	logic        py_neg;
	logic [11:0] ymag;

	logic        v_s2;
	logic [10:0] i_s2;
	logic [10:0] j_s2;
	logic [10:0] s_s2;
	logic [10:0] t_s2;
	logic [41:0] rb_prod_s2;
	logic [41:0] rt_prod_s2;
	logic [41:0] hy_prod_s2;
	logic [22:0] fi_prod_s2;
	logic        seam_s2;
	logic        border_s2;
	logic        py_neg_s2;

	logic        v_s3;
	logic [10:0] i_s3;
	logic [10:0] j_s3;
	logic [10:0] s_s3;
	logic [10:0] t_s3;
	logic [41:0] rad_num_s3;
	logic [41:0] hy_prod_s3;
	side1_t      side1_s3;

	logic [31:0] ph_q;
	logic [31:0] tu_q;
	logic [31:0] tv_q;
	logic [31:0] rad_q;
	logic [31:0] py_q;
	logic        v_d;
	logic [$bits(side1_t)-1:0] side1_bits;
	side1_t      side1_d;
	side2_t      side2_in;

	logic        v_c;
	logic [$bits(side2_t)-1:0] side2_bits;
	side2_t      side2_c;
	logic signed [17:0] cs_c;
	logic signed [17:0] sn_c;

	logic               v_s4;
	logic signed [49:0] px_prod_s4;
	logic signed [49:0] pz_prod_s4;
	logic signed [17:0] nx_s4;
	logic signed [17:0] nz_s4;
	side2_t             side2_s4;

	logic          v_s5;
	cmt_pkg::vtx_t vtx_s5;

	function automatic logic signed [31:0] scale_q16(input logic signed [49:0] p);
		logic [49:0] mag;
		logic [49:0] sum;
		logic [33:0] q;
		logic [31:0] r;
		mag = p[49] ? 50'(-p) : p;
		sum = mag + 50'd32768;
		q = sum[49:16];
		if (q > 34'd2147483647) q = 34'd2147483647;
		r = q[31:0];
		scale_q16 = p[49] ? $signed(-r) : $signed(r);
	endfunction

	assign cfg_ready = 1'b1;
	assign busy = busy_q;
	assign accept = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_base_q <= 31'd65536;
			radius_top_q <= 31'd65536;
			cyl_height_q <= 31'd65536;
			slice_count_q <= 11'd16;
			stack_count_q <= 11'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cmt_pkg::REG_RADIUS_BASE: radius_base_q <= cfg_data[30:0];
				cmt_pkg::REG_RADIUS_TOP: radius_top_q <= cfg_data[30:0];
				cmt_pkg::REG_CYL_HEIGHT: cyl_height_q <= cfg_data[30:0];
				cmt_pkg::REG_SLICE_COUNT: slice_count_q <= cfg_data[10:0];
				cmt_pkg::REG_STACK_COUNT: stack_count_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		s_sat = (slice_count_q == '0) ? 11'd1 : slice_count_q;
		if (32'(s_sat) > MAX_SLICES) s_sat = 11'(MAX_SLICES);
		t_sat = (stack_count_q == '0) ? 11'd1 : stack_count_q;
		if (32'(t_sat) > MAX_STACKS) t_sat = 11'(MAX_STACKS);
		i_sat = (slice_index > s_sat) ? s_sat : slice_index;
		j_sat = (stack_index > t_sat) ? t_sat : stack_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			busy_q <= accept;
			v_s1 <= accept & ((radius_base_q != '0) | (radius_top_q != '0));
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_c;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_sat;
		j_s1 <= j_sat;
		s_s1 <= s_sat;
		t_s1 <= t_sat;
	end

	assign two_j = {j_s1, 1'b0};
	assign t12 = {1'b0, t_s1};
	assign py_neg = two_j < t12;
	assign ymag = py_neg ? t12 - two_j : two_j - t12;

	always_ff @(posedge clk) begin
		i_s2 <= i_s1;
		j_s2 <= j_s1;
		s_s2 <= s_s1;
		t_s2 <= t_s1;
		rb_prod_s2 <= 42'(radius_base_q) * 42'(t_s1 - j_s1);
		rt_prod_s2 <= 42'(radius_top_q) * 42'(j_s1);
		hy_prod_s2 <= 42'(cyl_height_q) * 42'(ymag[10:0]);
		fi_prod_s2 <= 23'(12'(t_s1) + 12'd1) * 23'(i_s1);
		seam_s2 <= (i_s1 == '0) | (i_s1 == s_s1);
		border_s2 <= (i_s1 == s_s1) | (j_s1 == t_s1);
		py_neg_s2 <= py_neg;
	end

	always_ff @(posedge clk) begin
		i_s3 <= i_s2;
		j_s3 <= j_s2;
		s_s3 <= s_s2;
		t_s3 <= t_s2;
		rad_num_s3 <= rb_prod_s2 + rt_prod_s2;
		hy_prod_s3 <= hy_prod_s2;
		side1_s3.seam <= seam_s2;
		side1_s3.border <= border_s2;
		side1_s3.py_neg <= py_neg_s2;
		side1_s3.first <= 21'(23'(j_s2) + fi_prod_s2);
		side1_s3.second <= 21'(23'(j_s2) + fi_prod_s2 + 23'(t_s2) + 23'd1);
	end

	cmt_div #(.DW(11), .QW(cmt_pkg::DIV_STEPS)) u_div_phase (
		.clk(clk), .num({i_s3, 32'd0}), .den(s_s3), .quo(ph_q)
	);
	cmt_div #(.DW(11), .QW(cmt_pkg::DIV_STEPS)) u_div_tu (
		.clk(clk), .num({16'd0, i_s3, 16'd0}), .den(s_s3), .quo(tu_q)
	);
	cmt_div #(.DW(11), .QW(cmt_pkg::DIV_STEPS)) u_div_tv (
		.clk(clk), .num({16'd0, j_s3, 16'd0}), .den(t_s3), .quo(tv_q)
	);
	cmt_div #(.DW(11), .QW(cmt_pkg::DIV_STEPS)) u_div_rad (
		.clk(clk), .num({1'b0, rad_num_s3}), .den(t_s3), .quo(rad_q)
	);
	cmt_div #(.DW(12), .QW(cmt_pkg::DIV_STEPS)) u_div_py (
		.clk(clk), .num({2'b0, hy_prod_s3}), .den({t_s3, 1'b0}), .quo(py_q)
	);

	cmt_dly #(.W($bits(side1_t)), .N(cmt_pkg::DIV_LAT)) u_dly_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_data(side1_s3),
		.out_valid(v_d), .out_data(side1_bits)
	);
	assign side1_d = side1_t'(side1_bits);

	always_comb begin
		side2_in.rad = rad_q[30:0];
		side2_in.tu = 17'h10000 - tu_q[16:0];
		side2_in.tv = 17'h10000 - tv_q[16:0];
		side2_in.py = side1_d.py_neg ? -$signed({1'b0, py_q[30:0]})
			: $signed({1'b0, py_q[30:0]});
		side2_in.border = side1_d.border;
		side2_in.first = side1_d.first;
		side2_in.second = side1_d.second;
	end

	cmt_cordic u_cordic (
		.clk(clk), .phase(ph_q), .seam(side1_d.seam), .cs(cs_c), .sn(sn_c)
	);

	cmt_dly #(.W($bits(side2_t)), .N(cmt_pkg::CORDIC_LAT)) u_dly_trig (
		.clk(clk), .arst_n(arst_n), .in_valid(v_d), .in_data(side2_in),
		.out_valid(v_c), .out_data(side2_bits)
	);
	assign side2_c = side2_t'(side2_bits);

	always_ff @(posedge clk) begin
		px_prod_s4 <= 50'(cs_c) * 50'($signed({1'b0, side2_c.rad}));
		pz_prod_s4 <= 50'(sn_c) * 50'($signed({1'b0, side2_c.rad}));
		nx_s4 <= cs_c;
		nz_s4 <= sn_c;
		side2_s4 <= side2_c;
	end

	always_ff @(posedge clk) begin
		vtx_s5.px <= scale_q16(px_prod_s4);
		vtx_s5.pz <= scale_q16(pz_prod_s4);
		vtx_s5.py <= side2_s4.py;
		vtx_s5.tu <= side2_s4.tu;
		vtx_s5.tv <= side2_s4.tv;
		vtx_s5.nx <= nx_s4;
		vtx_s5.nz <= nz_s4;
		vtx_s5.border <= side2_s4.border;
		vtx_s5.first <= side2_s4.first;
		vtx_s5.second <= side2_s4.second;
	end

	cmt_emit u_emit (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .in_vtx(vtx_s5),
		.strobe(strobe), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v), .norm_x(norm_x), .norm_z(norm_z),
		.tri_valid(tri_valid), .tri_idx_a(tri_idx_a), .tri_idx_b(tri_idx_b),
		.tri_idx_c(tri_idx_c), .last_result(last_result)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q) else $error("busy not raised after accept");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q) else $error("busy held two cycles");
	a_seam_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && vtx_s5.nx > 18'sd65536 |-> 1'b0) else $error("normal out of range");

endmodule
